// ----- hw/rtl/twsbm_pkg.sv -----
package twsbm_pkg;

    localparam int READ_BITS    = 16;
    localparam int RESET_PULSES = 10;

    localparam logic [1:0] OP_IDLE  = 2'd0;
    localparam logic [1:0] OP_SEND  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_RESET = 2'd3;

    localparam logic [1:0] SMP_NONE = 2'd0;
    localparam logic [1:0] SMP_ACK  = 2'd1;
    localparam logic [1:0] SMP_BIT  = 2'd2;

    localparam logic [15:0] PHASE_LENGTH_RESET = 16'd10;

    localparam logic [5:0] SEND_ADDR_FIRST = 6'd7;
    localparam logic [5:0] SEND_CMD_FIRST  = 6'd13;
    localparam logic [5:0] SEND_RELEASE    = 6'd23;
    localparam logic [5:0] SEND_ACK        = 6'd24;
    localparam logic [6:0] START_CLK       = 7'b0110110;
    localparam logic [6:0] START_PULL      = 7'b0011100;
    localparam logic [2:0] CMD_MSB         = 3'd4;

    localparam bit         READ_HAS_ACK    = READ_BITS > 8;
    localparam logic [5:0] READ_ACK_FIRST  = 6'd16;
    localparam logic [5:0] READ_ACK_HIGH   = 6'd17;
    localparam logic [5:0] READ_ACK_END    = 6'd19;
    localparam logic [5:0] READ_ACK_PHASES = 6'd3;
    localparam logic [5:0] READ_LAST_J     = 6'(2 * READ_BITS - 1);
    localparam logic [5:0] RESET_LAST      = 6'(2 * RESET_PULSES - 1);

    localparam int IN_W  = 8;
    localparam int OUT_W = 24;

    typedef struct packed {
        logic       clk;
        logic       pull;
        logic [1:0] smp;
        logic       last;
    } phase_t;

    function automatic phase_t phase_decode(input logic [1:0] op, input logic [5:0] idx,
                                            input logic [4:0] cmd);
        phase_t     p;
        logic [5:0] k;
        logic [5:0] j;
        logic [2:0] b;
        p = '0;
        k = idx - SEND_CMD_FIRST;
        b = k[3:1];
        j = idx;
        unique case (op)
            OP_SEND:
            begin
                if (idx < SEND_ADDR_FIRST)
                begin
                    p.clk  = START_CLK[idx[2:0]];
                    p.pull = START_PULL[idx[2:0]];
                end
                else if (idx < SEND_CMD_FIRST)
                begin
                    p.clk  = ~idx[0];
                    p.pull = 1'b1;
                end
                else if (idx < SEND_RELEASE)
                begin
                    p.clk  = k[0];
                    p.pull = ~cmd[CMD_MSB - b];
                end
                else if (idx == SEND_RELEASE)
                begin
                    p.clk = 1'b0;
                end
                else if (idx == SEND_ACK)
                begin
                    p.clk = 1'b1;
                    p.smp = SMP_ACK;
                end
                else
                begin
                    p.last = 1'b1;
                end
            end
            OP_READ:
            begin
                if (READ_HAS_ACK && idx >= READ_ACK_FIRST && idx < READ_ACK_END)
                begin
                    p.clk  = (idx == READ_ACK_HIGH);
                    p.pull = 1'b1;
                end
                else
                begin
                    if (READ_HAS_ACK && idx >= READ_ACK_END)
                    begin
                        j = idx - READ_ACK_PHASES;
                    end
                    p.clk = ~j[0];
                    p.smp = j[0] ? SMP_BIT : SMP_NONE;
                    if (j >= READ_LAST_J)
                    begin
                        p.last = 1'b1;
                        p.clk  = 1'b0;
                        p.smp  = SMP_BIT;
                    end
                end
            end
            OP_RESET:
            begin
                p.clk = ~idx[0];
                if (idx >= RESET_LAST)
                begin
                    p.last = 1'b1;
                    p.clk  = 1'b0;
                end
            end
            default:
            begin
                p = '0;
            end
        endcase
        return p;
    endfunction

endpackage

// ----- hw/rtl/two_wire_sensor_bus_master.sv -----
// An input beat passes the input register, then the result register, to become its result beat.
// Throughput: one beat per cycle unless m_tready stalls a result; phase sequencer updates once per accepted beat.
// Result register decouples the sides: a new beat is taken while a result waits, if the input register is empty.
// Reset (rst_n low, asynchronous): idle, no beats held, phase_length back to 10,
// ack flag and received word cleared.
module two_wire_sensor_bus_master
    import twsbm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,  // operation[1:0], command[6:2], data_in[7]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,  // clock_out[0], data_pull_low[1], busy_res[2],
                                        // done_res[3], ack_received[4], read_value[20:5]
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [15:0]       cfg_data
);

    logic              in_valid_reg;
    logic [IN_W-1:0]   in_data_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic              advance;

    logic [15:0] phase_length_reg;
    logic [15:0] phase_count_reg, phase_count_next;
    logic [5:0]  step_reg, step_next;
    logic [1:0]  act_reg, act_next;
    logic [4:0]  cmd_reg, cmd_next;
    logic [15:0] rx_reg, rx_next;
    logic        ack_reg, ack_next;
    logic [OUT_W-1:0] out_data_next;

    logic [1:0]  op;
    logic [4:0]  cmd_in;
    logic        din;
    logic [15:0] len;
    logic [15:0] count_inc;
    phase_t      ph;
    logic        done;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    assign op     = in_data_reg[1:0];
    assign cmd_in = in_data_reg[6:2];
    assign din    = in_data_reg[7];
    assign len    = (phase_length_reg == 16'd0) ? 16'd1 : phase_length_reg;

    always_comb
    begin
        act_next         = act_reg;
        step_next        = step_reg;
        phase_count_next = phase_count_reg;
        cmd_next         = cmd_reg;
        rx_next          = rx_reg;
        ack_next         = ack_reg;
        done             = 1'b0;
        if (act_reg == OP_IDLE && op != OP_IDLE)
        begin
            act_next         = op;
            step_next        = 6'd0;
            phase_count_next = 16'd0;
            if (op == OP_SEND)
            begin
                cmd_next = cmd_in;
            end
            if (op == OP_READ)
            begin
                rx_next = 16'd0;
            end
        end
        ph        = phase_decode(act_next, step_next, cmd_next);
        count_inc = phase_count_next + 16'd1;
        if (act_next == OP_IDLE)
        begin
            ph = '0;
        end
        else
        begin
            phase_count_next = count_inc;
            if (count_inc >= len)
            begin
                phase_count_next = 16'd0;
                if (ph.smp == SMP_ACK)
                begin
                    ack_next = ~din;
                end
                if (ph.smp == SMP_BIT)
                begin
                    rx_next = {rx_next[14:0], din};
                end
                if (ph.last)
                begin
                    act_next  = OP_IDLE;
                    step_next = 6'd0;
                    done      = 1'b1;
                end
                else
                begin
                    step_next = step_next + 6'd1;
                end
            end
        end
        out_data_next = {3'd0, rx_next, ack_next, done, (act_next != OP_IDLE),
                         ph.pull, ph.clk};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_length_reg <= PHASE_LENGTH_RESET;
            phase_count_reg  <= 16'd0;
            step_reg         <= 6'd0;
            act_reg          <= OP_IDLE;
            cmd_reg          <= 5'd0;
            rx_reg           <= 16'd0;
            ack_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                phase_length_reg <= cfg_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                phase_count_reg <= phase_count_next;
                step_reg        <= step_next;
                act_reg         <= act_next;
                cmd_reg         <= cmd_next;
                rx_reg          <= rx_next;
                ack_reg         <= ack_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[3]) |-> !m_tdata[2])
        else $error("done result still reports busy");

    a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (act_reg == OP_IDLE) |-> (step_reg == 6'd0 && phase_count_reg == 16'd0))
        else $error("idle sequencer with stale step or count");

    a_count_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (act_reg != OP_IDLE) |-> (phase_count_reg < len))
        else $error("phase count beyond phase length");

    a_result_follows_advance: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced beat produced no result");

endmodule
